>>> hw/rtl/fgn_pkg.sv
// Package: constants, types and the gradient table for the fractal gradient noise block.
`timescale 1ns / 1ps
package fgn_pkg;

  localparam int TableBits  = 10;
  localparam int MaxOctaves = 8;
  localparam int QuadBits   = TableBits - 2;
  localparam int QuadSize   = 1 << QuadBits;
  localparam int LeftW      = $clog2(MaxOctaves + 1);
  localparam int AccW       = 48;
  localparam int ContribW   = 40;
  localparam int GradW      = 18;

  localparam logic [31:0] HashMulA = 32'd3284157443;
  localparam logic [31:0] HashMulB = 32'd1911520717;
  localparam logic [31:0] HashMulC = 32'd2048419325;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgInvScale = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOctaves  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInvLac   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPersist  = 3'd3;

  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;

  localparam longint CordicGain = 64'sd652032874;
  localparam longint AtanTurns [16] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
    64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861
  };

  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
  } grad_t;

  // Per-octave context that travels with a transaction round the pipeline.
  typedef struct packed {
    logic [31:0]            ux;
    logic [31:0]            uy;
    logic [23:0]            s;
    logic [30:0]            w;
    logic [23:0]            s_next;
    logic [30:0]            w_next;
    logic signed [AccW-1:0] acc;
    logic [LeftW-1:0]       left;
  } ctx_t;

  typedef logic [QuadSize-1:0][2*GradW-1:0] grad_rom_t;

  function automatic logic signed [GradW-1:0] clamp_unit(longint v);
    longint r;
    r = v;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return GradW'(r);
  endfunction

  // First-quadrant sine/cosine by CORDIC, worked out at elaboration only.
  function automatic logic [2*GradW-1:0] cordic_entry(int n);
    longint x, y, z, dx, dy;
    logic signed [GradW-1:0] c, s;
    x = CordicGain;
    y = 0;
    z = longint'(n) << (32 - TableBits);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanTurns[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanTurns[i];
      end
    end
    c = clamp_unit((x + 8192) >>> 14);
    s = clamp_unit((y + 8192) >>> 14);
    return {s, c};
  endfunction

  function automatic grad_rom_t build_rom();
    grad_rom_t r;
    for (int n = 0; n < QuadSize; n++) r[n] = cordic_entry(n);
    return r;
  endfunction

  localparam grad_rom_t GradRom = build_rom();

  function automatic logic [31:0] rot16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

>>> hw/rtl/fgn_point_if.sv
// Interface: input channel carrying one sample point.
`timescale 1ns / 1ps
interface fgn_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

>>> hw/rtl/fgn_noise_if.sv
// Interface: output channel carrying one noise sum.
`timescale 1ns / 1ps
interface fgn_noise_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] noise_sum;
  modport source (output valid, output noise_sum, input ready);
  modport sink (input valid, input noise_sum, output ready);
endinterface

>>> hw/rtl/fgn_grad_lookup.sv
// Gradient lookup: quadrant table read and quadrant rotation of one hash index.
`timescale 1ns / 1ps
module fgn_grad_lookup import fgn_pkg::*; (
  input  logic [TableBits-1:0] idx_i,
  output grad_t                grad_o
);
  logic [1:0]              quad;
  logic [2*GradW-1:0]      entry;
  logic signed [GradW-1:0] c, s;

  assign quad  = idx_i[TableBits-1 -: 2];
  assign entry = GradRom[idx_i[QuadBits-1:0]];
  assign s     = entry[2*GradW-1:GradW];
  assign c     = entry[GradW-1:0];

  // gx is the sine, gy the cosine
  always_comb begin
    case (quad)
      QuadFirst: begin
        grad_o.gy = c;  grad_o.gx = s;
      end
      QuadSecond: begin
        grad_o.gy = -s; grad_o.gx = c;
      end
      QuadThird: begin
        grad_o.gy = -c; grad_o.gx = -s;
      end
      default: begin
        grad_o.gy = s;  grad_o.gx = -c;
      end
    endcase
  end
endmodule

>>> hw/rtl/fgn_octave_pipe.sv
// Octave pipeline: nine register stages from scaled point to weighted contribution.
`timescale 1ns / 1ps
module fgn_octave_pipe import fgn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  ctx_t                       ctx_i,
  input  logic [17:0]                lac_i,
  input  logic [17:0]                pers_i,
  output logic                       valid_o,
  output ctx_t                       ctx_o,
  output logic signed [ContribW-1:0] contrib_o
);
  logic [9:1] v_q;
  ctx_t       ctx_q [9:1];
  ctx_t       ctx1_d;

  // stage 1: scale the point, step scale and weight for the next octave
  logic [55:0] sx_q, sy_q;
  logic [41:0] sn_prod;
  logic [48:0] wn_prod;
  always_comb begin
    ctx1_d  = ctx_i;
    sn_prod = 42'(ctx_i.s) * 42'(lac_i);
    wn_prod = 49'(ctx_i.w) * 49'(pers_i);
    ctx1_d.s_next = (|sn_prod[41:40]) ? 24'hFFFFFF : sn_prod[39:16];
    ctx1_d.w_next = (|wn_prod[48:47]) ? 31'h7FFFFFFF : wn_prod[46:16];
  end

  // stage 2: first hash multiply for both x columns
  // the raw product is Q.32: cell above bit 32, fraction in bits 31..16
  logic [31:0] ix, ix1;
  logic [31:0] iy_q2, iy1_q2, hax0_q2, hax1_q2;
  logic [15:0] fx_q2, fy_q2;
  assign ix  = {8'd0, sx_q[55:32]};
  assign ix1 = ix + 32'd1;

  // stage 3: second hash multiply per corner
  logic [31:0] ha_q3 [4];
  logic [31:0] hb_q3 [4];
  logic [31:0] cy3 [4];
  logic [31:0] ha3 [4];
  logic [15:0] fx_q3, fy_q3;
  assign cy3[0] = iy_q2;   assign cy3[1] = iy_q2;
  assign cy3[2] = iy1_q2;  assign cy3[3] = iy1_q2;
  assign ha3[0] = hax0_q2; assign ha3[1] = hax1_q2;
  assign ha3[2] = hax0_q2; assign ha3[3] = hax1_q2;

  // stage 4: final hash multiply, keep the table index
  logic [31:0]          hc4 [4];
  logic [TableBits-1:0] idx_q4 [4];
  logic [15:0]          fx_q4, fy_q4;
  assign hc4[0] = (ha_q3[0] ^ rot16(hb_q3[0])) * HashMulC;
  assign hc4[1] = (ha_q3[1] ^ rot16(hb_q3[1])) * HashMulC;
  assign hc4[2] = (ha_q3[2] ^ rot16(hb_q3[2])) * HashMulC;
  assign hc4[3] = (ha_q3[3] ^ rot16(hb_q3[3])) * HashMulC;

  // stage 5: gradients
  grad_t       grad_d [4];
  grad_t       grad_q5 [4];
  logic [15:0] fx_q5, fy_q5;

  // stage 6: corner terms
  logic signed [17:0] fxs5, rxs5, fys5, rys5;
  logic signed [20:0] e_q6, f_q6, g_q6, h_q6;
  logic [15:0]        fx_q6, fy_q6;
  assign fxs5 = $signed({2'b00, fx_q5});
  assign fys5 = $signed({2'b00, fy_q5});
  assign rxs5 = 18'sd65536 - fxs5;
  assign rys5 = 18'sd65536 - fys5;

  // stage 7: interpolation products along x
  logic signed [17:0] fxs6;
  logic signed [39:0] t1_q7, t2_q7;
  logic signed [20:0] e_q7, g_q7;
  logic [15:0]        fy_q7;
  assign fxs6 = $signed({2'b00, fx_q6});

  // stage 8: interpolation product along y
  logic signed [17:0] fys7;
  logic signed [23:0] u8, v8;
  logic signed [23:0] u_q8;
  logic signed [42:0] m_q8;
  assign fys7 = $signed({2'b00, fy_q7});
  assign u8   = 24'(e_q7) + 24'(t1_q7 >>> 16);
  assign v8   = 24'(g_q7) + 24'(t2_q7 >>> 16);

  // stage 9: weight the octave value
  logic signed [23:0] val8;
  logic signed [31:0] ws8;
  logic signed [55:0] prod8;
  logic signed [ContribW-1:0] contrib_q9;
  assign val8  = u_q8 + 24'(m_q8 >>> 16);
  assign ws8   = $signed({1'b0, ctx_q[8].w});
  assign prod8 = 56'(val8) * 56'(ws8);

  for (genvar k = 0; k < 4; k++) begin : g_lookup
    fgn_grad_lookup u_lookup (
      .idx_i  (idx_q4[k]),
      .grad_o (grad_d[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[8:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[1] <= ctx1_d;
      for (int i = 2; i <= 9; i++) ctx_q[i] <= ctx_q[i-1];
      sx_q <= 56'(ctx_i.ux) * 56'(ctx_i.s);
      sy_q <= 56'(ctx_i.uy) * 56'(ctx_i.s);
      iy_q2   <= {8'd0, sy_q[55:32]};
      iy1_q2  <= {8'd0, sy_q[55:32]} + 32'd1;
      hax0_q2 <= ix * HashMulA;
      hax1_q2 <= ix1 * HashMulA;
      fx_q2   <= sx_q[31:16];
      fy_q2   <= sy_q[31:16];
      for (int k = 0; k < 4; k++) begin
        ha_q3[k]  <= ha3[k];
        hb_q3[k]  <= (cy3[k] ^ rot16(ha3[k])) * HashMulB;
        idx_q4[k] <= hc4[k][31 -: TableBits];
        grad_q5[k] <= grad_d[k];
      end
      fx_q3 <= fx_q2;  fy_q3 <= fy_q2;
      fx_q4 <= fx_q3;  fy_q4 <= fy_q3;
      fx_q5 <= fx_q4;  fy_q5 <= fy_q4;
      e_q6 <= 21'((37'(grad_q5[0].gx) * 37'(fxs5) + 37'(grad_q5[0].gy) * 37'(fys5)) >>> 16);
      f_q6 <= 21'((37'(grad_q5[1].gx) * 37'(rxs5) + 37'(grad_q5[1].gy) * 37'(fys5)) >>> 16);
      g_q6 <= 21'((37'(grad_q5[2].gx) * 37'(fxs5) + 37'(grad_q5[2].gy) * 37'(rys5)) >>> 16);
      h_q6 <= 21'((37'(grad_q5[3].gx) * 37'(rxs5) + 37'(grad_q5[3].gy) * 37'(rys5)) >>> 16);
      fx_q6 <= fx_q5;  fy_q6 <= fy_q5;
      t1_q7 <= 40'(fxs6) * 40'(22'(f_q6) - 22'(e_q6));
      t2_q7 <= 40'(fxs6) * 40'(22'(h_q6) - 22'(g_q6));
      e_q7  <= e_q6;
      g_q7  <= g_q6;
      fy_q7 <= fy_q6;
      u_q8  <= u8;
      m_q8  <= 43'(fys7) * 43'(25'(v8) - 25'(u8));
      contrib_q9 <= ContribW'(prod8 >>> 16);
    end
  end

  assign valid_o   = v_q[9];
  assign ctx_o     = ctx_q[9];
  assign contrib_o = contrib_q9;
endmodule

>>> hw/rtl/fractal_gradient_noise_2d.sv
// Top level: configuration registers, octave recirculation, accumulation and output register.
`timescale 1ns / 1ps
// Fractal gradient noise over a 2-D point. Each point makes one pass per octave,
// max(1, min(octave_count, 8)) passes in all, through a ten-stage octave pipeline
// (nine stages plus the accumulate stage). A point whose octaves are not finished
// re-enters the pipeline head and takes priority over new input; new points enter
// while others are still in flight, all through the single shared octave pipeline.
// The result sits in an output register; the pipeline keeps running under a
// stalled output unless a finished point is waiting behind it.
module fractal_gradient_noise_2d import fgn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  fgn_point_if.sink          point_i,
  fgn_noise_if.source        noise_o
);
  logic [23:0] inv_scale_q;
  logic [3:0]  octaves_q;
  logic [17:0] inv_lac_q;
  logic [17:0] persist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= 24'd4096;
      octaves_q   <= 4'd4;
      inv_lac_q   <= 18'd32768;
      persist_q   <= 18'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInvScale: inv_scale_q <= cfg_data_i;
        CfgOctaves:  octaves_q   <= cfg_data_i[3:0];
        CfgInvLac:   inv_lac_q   <= cfg_data_i[17:0];
        CfgPersist:  persist_q   <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  logic                       v10_q;
  ctx_t                       ctx10_q, ctx10_d;
  logic                       done10, recirc, adv;
  logic                       pipe_valid, pipe_valid_o;
  ctx_t                       pipe_ctx, pipe_ctx_o, entry_ctx;
  logic signed [ContribW-1:0] contrib;
  logic                       out_valid_q;
  logic signed [31:0]         noise_q;

  assign done10 = (ctx10_q.left == '0);
  assign recirc = v10_q && !done10;
  // hold everything only when a finished point cannot leave
  assign adv    = !(out_valid_q && !noise_o.ready && v10_q && done10);
  assign point_i.ready = adv && !recirc;

  always_comb begin
    entry_ctx      = '0;
    entry_ctx.ux   = point_i.point_x[31] ? 32'(-point_i.point_x) : point_i.point_x;
    entry_ctx.uy   = point_i.point_y[31] ? 32'(-point_i.point_y) : point_i.point_y;
    entry_ctx.s    = inv_scale_q;
    entry_ctx.w    = 31'd65536;
    entry_ctx.left = (int'(octaves_q) > MaxOctaves) ? LeftW'(MaxOctaves) : LeftW'(octaves_q);
    pipe_ctx       = entry_ctx;
    if (recirc) begin
      pipe_ctx   = ctx10_q;
      pipe_ctx.s = ctx10_q.s_next;
      pipe_ctx.w = ctx10_q.w_next;
    end
  end
  assign pipe_valid = recirc || point_i.valid;

  fgn_octave_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (pipe_valid),
    .ctx_i     (pipe_ctx),
    .lac_i     (inv_lac_q),
    .pers_i    (persist_q),
    .valid_o   (pipe_valid_o),
    .ctx_o     (pipe_ctx_o),
    .contrib_o (contrib)
  );

  // accumulate the octave; a zero octave count adds nothing
  always_comb begin
    ctx10_d = pipe_ctx_o;
    if (pipe_ctx_o.left != '0) begin
      ctx10_d.acc  = pipe_ctx_o.acc + AccW'(contrib);
      ctx10_d.left = pipe_ctx_o.left - LeftW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (adv) begin
      v10_q <= pipe_valid_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) ctx10_q <= ctx10_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || noise_o.ready) begin
      out_valid_q <= v10_q && done10;
    end
  end

  // saturate to 32-bit signed on the way out
  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || noise_o.ready) && v10_q && done10) begin
      if (ctx10_q.acc > AccW'(64'sd2147483647)) begin
        noise_q <= 32'sh7FFFFFFF;
      end else if (ctx10_q.acc < AccW'(-64'sd2147483648)) begin
        noise_q <= 32'sh80000000;
      end else begin
        noise_q <= ctx10_q.acc[31:0];
      end
    end
  end

  assign noise_o.valid     = out_valid_q;
  assign noise_o.noise_sum = noise_q;

  a_no_entry_on_recirc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recirc |-> !point_i.ready)
    else $error("new transaction taken while an octave pass re-enters");

  a_recirc_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recirc && adv) |=> u_pipe.v_q[1])
    else $error("recirculating point lost at pipeline head");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v10_q && done10))
    else $error("result produced without a finished point");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v10_q |-> (int'(ctx10_q.left) < MaxOctaves))
    else $error("octave count out of range after accumulate");
endmodule

>>> verif/fractal_gradient_noise_2d_test.sv
// Self-checking testbench for the fractal gradient noise block.
`timescale 1ns / 1ps
module fractal_gradient_noise_2d_test;
  import fgn_pkg::*;

  localparam int PipeDepth = 10;
  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgInvScale;
  logic [23:0] cfg_data_i = '0;

  fgn_point_if point_ch ();
  fgn_noise_if noise_ch ();

  fractal_gradient_noise_2d u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .point_i(point_ch.sink), .noise_o(noise_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers.
  logic [23:0] shadow_scale;
  logic [3:0]  shadow_octaves;
  logic [17:0] shadow_lac;
  logic [17:0] shadow_persist;

  logic signed [31:0] expected_sums[$];
  int errors = 0;
  int points_sent = 0;
  int sums_checked = 0;
  int quiet_cycles = 0;
  bit idle_enable = 1'b1;
  bit timed_out = 1'b0;

  initial begin
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    noise_ch.ready = 1'b0;
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void unit_gradient(logic [31:0] cx, logic [31:0] cy,
                                        output longint gx, output longint gy);
    logic [31:0] a, b;
    logic [31:0] phase;
    logic [1:0] quad;
    longint x, y, z, dx, dy, c, s;
    a = cx * HashMulA;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * HashMulB;
    a = a ^ {b[15:0], b[31:16]};
    a = a * HashMulC;
    phase = {a[31 -: TableBits], {(32 - TableBits){1'b0}}};
    quad = phase[31:30];
    z = longint'(phase[29:0]);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanTurns[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanTurns[i];
      end
    end
    c = floor_shift(x + 8192, 14);
    s = floor_shift(y + 8192, 14);
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (s > 65536) s = 65536;
    if (s < -65536) s = -65536;
    case (quad)
      2'd0: begin gy = c; gx = s; end
      2'd1: begin gy = -s; gx = c; end
      2'd2: begin gy = -c; gx = -s; end
      default: begin gy = s; gx = -c; end
    endcase
  endfunction

  function automatic longint blend(longint u, longint v, longint t);
    return u + floor_shift(t * (v - u), 16);
  endfunction

  function automatic longint octave_noise(logic [31:0] ux, logic [31:0] uy, logic [23:0] s);
    logic [63:0] sx, sy;
    logic [31:0] ix, iy;
    longint fx, fy, rx, ry, ax, ay, bx, by, cx, cy, dx, dy, e, f, g, h;
    sx = ({32'd0, ux} * {40'd0, s}) >> 16;
    sy = ({32'd0, uy} * {40'd0, s}) >> 16;
    ix = sx[47:16];
    iy = sy[47:16];
    fx = longint'(sx[15:0]);
    fy = longint'(sy[15:0]);
    rx = 65536 - fx;
    ry = 65536 - fy;
    unit_gradient(ix, iy, ax, ay);
    unit_gradient(ix + 32'd1, iy, bx, by);
    unit_gradient(ix, iy + 32'd1, cx, cy);
    unit_gradient(ix + 32'd1, iy + 32'd1, dx, dy);
    e = floor_shift(ax * fx + ay * fy, 16);
    f = floor_shift(bx * rx + by * fy, 16);
    g = floor_shift(cx * fx + cy * ry, 16);
    h = floor_shift(dx * rx + dy * ry, 16);
    return blend(blend(e, f, fx), blend(g, h, fx), fy);
  endfunction

  function automatic logic signed [31:0] fractal_sum(logic signed [31:0] px,
                                                     logic signed [31:0] py);
    logic [31:0] ux, uy;
    longint s, w, acc;
    int count;
    ux = px[31] ? -px : px;
    uy = py[31] ? -py : py;
    count = (shadow_octaves > MaxOctaves) ? MaxOctaves : shadow_octaves;
    s = shadow_scale;
    w = 65536;
    acc = 0;
    for (int k = 0; k < count; k++) begin
      acc += floor_shift(octave_noise(ux, uy, s[23:0]) * w, 16);
      s = (s * shadow_lac) >>> 16;
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
      w = (w * shadow_persist) >>> 16;
      if (w > 64'h7FFFFFFF) w = 64'h7FFFFFFF;
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // Hold the enable for one edge, then drop it again before the next write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgInvScale: shadow_scale = value;
      CfgOctaves:  shadow_octaves = value[3:0];
      CfgInvLac:   shadow_lac = value[17:0];
      CfgPersist:  shadow_persist = value[17:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [23:0] scale, logic [3:0] octs, logic [17:0] lac,
                           logic [17:0] pers);
    write_reg(CfgInvScale, scale);
    write_reg(CfgOctaves, {20'd0, octs});
    write_reg(CfgInvLac, {6'd0, lac});
    write_reg(CfgPersist, {6'd0, pers});
  endtask

  // Leave valid high after the transaction; drain() or an idle gap in the next call drops it.
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      point_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    point_ch.valid <= 1'b1;
    point_ch.point_x <= px;
    point_ch.point_y <= py;
    do @(posedge clk_i); while (!point_ch.ready);
    expected_sums.push_back(fractal_sum(px, py));
    points_sent++;
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (PipeDepth * MaxOctaves + 4) @(posedge clk_i);
  endtask

  // Receiver back-pressure in bursts while idle_enable is set.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_enable && $urandom_range(0, 2) == 0) begin
        noise_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      noise_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (noise_ch.valid && noise_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected noise_sum transaction, actual %0d", $time,
                 noise_ch.noise_sum);
        errors++;
      end else begin
        if (noise_ch.noise_sum !== expected_sums[0]) begin
          $display("%0t: noise_sum mismatch, expected %0d actual %0d", $time,
                   expected_sums[0], noise_ch.noise_sum);
          errors++;
        end
        void'(expected_sums.pop_front());
        sums_checked++;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((point_ch.valid && point_ch.ready) || (noise_ch.valid && noise_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("Timeout after %0d quiet cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  task automatic test_reset_values();
    shadow_scale = 24'd4096;
    shadow_octaves = 4'd4;
    shadow_lac = 18'd32768;
    shadow_persist = 18'd32768;
    send_point(32'sh0001_8000, -32'sh0002_4000);
    send_point(32'sd0, 32'sd0);
    drain();
  endtask

  task automatic test_directed();
    configure(24'h010000, 4'd8, 18'h3FFFF, 18'h3FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h0000_FFFF, 32'hFFFF_0000);
    drain();
    // Zero octaves, and a count above the maximum.
    write_reg(CfgOctaves, 24'd0);
    send_point(32'h1234_5678, 32'h0ABC_DEF0);
    drain();
    write_reg(CfgOctaves, 24'd15);
    send_point(32'h1234_5678, 32'h0ABC_DEF0);
    drain();
    // Zero scale, and a scale that decays to nothing.
    write_reg(CfgInvScale, 24'd0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    configure(24'd1, 4'd3, 18'd1, 18'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    // Cell indices near the top of the range, and saturating sum.
    configure(24'hFFFFFF, 4'd8, 18'h3FFFF, 18'h3FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_0000);
    send_point(32'h0FFF_FFFF, 32'hC000_0001);
    send_point(32'h0000_8000, 32'h0000_4000);
    drain();
    // Register index beyond the four is dropped.
    write_reg(3'd5, 24'hFFFFFF);
    write_reg(3'd7, 24'h000000);
    send_point(32'h0003_2000, 32'h0001_1000);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      configure($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 24'h40000)),
                4'($urandom_range(0, 15)), 18'($urandom), 18'($urandom));
      for (int n = 0; n < per_phase; n++) send_point(rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random(12, 50);
    idle_enable = 1'b0;
    test_random(3, 50);
    drain();
    $display("Covered %0d points, %0d sums checked, across directed and random settings",
             points_sent, sums_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fgn_pkg.sv
hw/rtl/fgn_point_if.sv
hw/rtl/fgn_noise_if.sv
hw/rtl/fgn_grad_lookup.sv
hw/rtl/fgn_octave_pipe.sv
hw/rtl/fractal_gradient_noise_2d.sv
verif/fractal_gradient_noise_2d_test.sv
